// ===== rtl/decimal_text_to_fixed_point_core_defines.svh =====
// assertion macros for the top-level core, which checks itself
`ifndef DECIMAL_TEXT_TO_FIXED_POINT_CORE_DEFINES_SVH
`define DECIMAL_TEXT_TO_FIXED_POINT_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define DTTFP_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dttfp: same-cycle check failed");
// antecedent implies consequent in the next cycle
`define DTTFP_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dttfp: next-cycle check failed");
`else
`define DTTFP_ASSERT_IMP(label, clk, rst, ante, cons)
`define DTTFP_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/dttfp_pkg.sv =====
package dttfp_pkg;

  localparam int unsigned GLYPH_W = 16;
  localparam int unsigned DEC_W   = 5;
  localparam int unsigned ACC_W   = 63;
  localparam int unsigned VAL_W   = 64;
  localparam int unsigned POW_W   = 60;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = 2;
  localparam int unsigned QUEUE_CW    = 3;

  localparam logic [GLYPH_W-1:0] CH_MINUS = 16'd45;
  localparam logic [GLYPH_W-1:0] CH_ZERO  = 16'd48;
  localparam logic [GLYPH_W-1:0] CH_NINE  = 16'd57;

  localparam logic [ACC_W-1:0] SAT_MAX = 63'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    REG_PERIOD_CODE    = 2'd0,
    REG_DECIMAL_PLACES = 2'd1,
    REG_RANGE_LOWER    = 2'd2,
    REG_RANGE_UPPER    = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    CLS_OTHER,
    CLS_MINUS,
    CLS_PERIOD,
    CLS_DIGIT
  } cls_t;

  // one classified character
  typedef struct packed {
    cls_t       cls;
    logic [3:0] digit;
    logic       last;
    logic       empty;
  } char_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // finished text handed to the scaling pipeline
  typedef struct packed {
    logic [ACC_W-1:0] acc;
    logic             neg;
    logic [DEC_W-1:0] scale;
    logic             adj;
    logic             zero;
  } job_t;

  function automatic logic [POW_W-1:0] pow10(input logic [DEC_W-1:0] k);
    logic [POW_W-1:0] r;
    case (k)
      5'd0:    r = 60'd1;
      5'd1:    r = 60'd10;
      5'd2:    r = 60'd100;
      5'd3:    r = 60'd1000;
      5'd4:    r = 60'd10000;
      5'd5:    r = 60'd100000;
      5'd6:    r = 60'd1000000;
      5'd7:    r = 60'd10000000;
      5'd8:    r = 60'd100000000;
      5'd9:    r = 60'd1000000000;
      5'd10:   r = 60'd10000000000;
      5'd11:   r = 60'd100000000000;
      5'd12:   r = 60'd1000000000000;
      5'd13:   r = 60'd10000000000000;
      5'd14:   r = 60'd100000000000000;
      5'd15:   r = 60'd1000000000000000;
      5'd16:   r = 60'd10000000000000000;
      5'd17:   r = 60'd100000000000000000;
      5'd18:   r = 60'd1000000000000000000;
      default: r = 60'd1;
    endcase
    return r;
  endfunction

  // largest magnitude that survives a multiply by 10^k
  function automatic logic [ACC_W-1:0] sat_div(input logic [DEC_W-1:0] k);
    logic [ACC_W-1:0] r;
    case (k)
      5'd0:    r = 63'd9223372036854775807;
      5'd1:    r = 63'd922337203685477580;
      5'd2:    r = 63'd92233720368547758;
      5'd3:    r = 63'd9223372036854775;
      5'd4:    r = 63'd922337203685477;
      5'd5:    r = 63'd92233720368547;
      5'd6:    r = 63'd9223372036854;
      5'd7:    r = 63'd922337203685;
      5'd8:    r = 63'd92233720368;
      5'd9:    r = 63'd9223372036;
      5'd10:   r = 63'd922337203;
      5'd11:   r = 63'd92233720;
      5'd12:   r = 63'd9223372;
      5'd13:   r = 63'd922337;
      5'd14:   r = 63'd92233;
      5'd15:   r = 63'd9223;
      5'd16:   r = 63'd922;
      5'd17:   r = 63'd92;
      5'd18:   r = 63'd9;
      default: r = SAT_MAX;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/dttfp_channels.sv =====
// character beats in
interface dttfp_char_if import dttfp_pkg::*;;
  logic               valid;
  logic               ready;
  logic [GLYPH_W-1:0] glyph;
  logic               last_char;
  logic               empty_text;

  modport source (output valid, glyph, last_char, empty_text, input ready);
  modport sink   (input valid, glyph, last_char, empty_text, output ready);
endinterface

// result beats out
interface dttfp_result_if import dttfp_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] value;
  logic                    adjusted;

  modport source (output valid, value, adjusted, input ready);
  modport sink   (input valid, value, adjusted, output ready);
endinterface

// register writes
interface dttfp_cfg_if import dttfp_pkg::*;;
  logic             valid;
  logic             ready;
  reg_index_t       index;
  logic [VAL_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/dttfp_front.sv =====
module dttfp_front import dttfp_pkg::*; (
  dttfp_char_if.sink         chars,
  input  logic [GLYPH_W-1:0] period_code,
  input  queue_status_t      q_status,
  output logic               push,
  output char_t              ent
);

  // take a beat whenever the queue has room
  assign chars.ready = !q_status.full;
  assign push        = chars.valid && !q_status.full;

  // minus wins over the separator, the separator over digits
  always_comb begin
    ent.digit = chars.glyph[3:0];
    ent.last  = chars.last_char;
    ent.empty = chars.empty_text;
    if (chars.glyph == CH_MINUS) begin
      ent.cls = CLS_MINUS;
    end else if (chars.glyph == period_code) begin
      ent.cls = CLS_PERIOD;
    end else if (chars.glyph >= CH_ZERO && chars.glyph <= CH_NINE) begin
      ent.cls = CLS_DIGIT;
    end else begin
      ent.cls = CLS_OTHER;
    end
  end

endmodule

// ===== rtl/dttfp_queue.sv =====
module dttfp_queue import dttfp_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  char_t         wr_ent,
  input  logic          pop,
  output char_t         rd_ent,
  output queue_status_t status
);

  char_t                 mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [QUEUE_CW-1:0]   count;

  assign status.full  = (count == QUEUE_CW'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign rd_ent       = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_ent;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QUEUE_CW'(1);
        2'b01:   count <= count - QUEUE_CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/dttfp_back.sv =====
module dttfp_back import dttfp_pkg::*; #(
  parameter int unsigned MAX_DECIMALS = 18
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [DEC_W-1:0] decimal_places,
  input  queue_status_t    q_status,
  input  char_t            ent,
  output logic             pop,
  output job_t             job,
  output logic             job_valid,
  input  logic             job_ready
);

  localparam logic [DEC_W-1:0] MaxDec = DEC_W'(MAX_DECIMALS);

  logic [ACC_W-1:0] acc, acc_next;
  logic             at_first, at_first_next;
  logic             neg_text, neg_text_next;
  logic             period_seen, period_seen_next;
  logic [DEC_W-1:0] dec_count, dec_count_next;
  logic             stopped, stopped_next;
  logic             adj_flag, adj_flag_next;

  logic [DEC_W-1:0] dec_eff;
  logic [DEC_W-1:0] dec_taken;
  logic [ACC_W+3:0] acc_wide;
  logic             is_end;
  logic             take_skip;

  assign dec_eff  = (decimal_places > MaxDec) ? MaxDec : decimal_places;
  // times ten plus digit by shift and add
  assign acc_wide = (ACC_W+4)'({acc, 3'b000}) + (ACC_W+4)'({acc, 1'b0})
                  + (ACC_W+4)'(ent.digit);
  assign is_end   = ent.last || ent.empty;

  // one character step
  always_comb begin
    acc_next         = acc;
    at_first_next    = at_first;
    neg_text_next    = neg_text;
    period_seen_next = period_seen;
    dec_count_next   = dec_count;
    stopped_next     = stopped;
    adj_flag_next    = adj_flag;
    take_skip        = 1'b0;
    if (!ent.empty) begin
      if (at_first) begin
        neg_text_next = (ent.cls == CLS_MINUS);
        at_first_next = 1'b0;
      end
      if (!stopped) begin
        // every character after the separator uses up a decimal place
        if (period_seen) begin
          if (dec_count >= dec_eff) begin
            adj_flag_next = 1'b1;
            take_skip     = 1'b1;
          end else begin
            dec_count_next = dec_count + DEC_W'(1);
          end
        end
        if (!take_skip) begin
          case (ent.cls)
            CLS_PERIOD: period_seen_next = 1'b1;
            CLS_DIGIT: begin
              if (|acc_wide[ACC_W+3:ACC_W]) begin
                acc_next      = SAT_MAX;
                adj_flag_next = 1'b1;
                stopped_next  = 1'b1;
              end else begin
                acc_next = acc_wide[ACC_W-1:0];
              end
            end
            default: ;
          endcase
        end
      end
    end
  end

  // hand-off of a finished text
  assign dec_taken = (dec_count_next < dec_eff) ? dec_count_next : dec_eff;
  assign job.acc   = acc_next;
  assign job.neg   = neg_text_next;
  assign job.scale = dec_eff - dec_taken;
  assign job.adj   = adj_flag_next;
  assign job.zero  = ent.empty && at_first;

  assign job_valid = !q_status.empty && is_end;
  assign pop       = !q_status.empty && (!is_end || job_ready);

  // text state, cleared after each result
  always_ff @(posedge clk) begin
    if (rst || (pop && is_end)) begin
      acc         <= '0;
      at_first    <= 1'b1;
      neg_text    <= 1'b0;
      period_seen <= 1'b0;
      dec_count   <= '0;
      stopped     <= 1'b0;
      adj_flag    <= 1'b0;
    end else if (pop) begin
      acc         <= acc_next;
      at_first    <= at_first_next;
      neg_text    <= neg_text_next;
      period_seen <= period_seen_next;
      dec_count   <= dec_count_next;
      stopped     <= stopped_next;
      adj_flag    <= adj_flag_next;
    end
  end

endmodule

// ===== rtl/dttfp_finish.sv =====
module dttfp_finish import dttfp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  job_t                    job,
  input  logic                    job_valid,
  output logic                    job_ready,
  input  logic signed [VAL_W-1:0] range_lower,
  input  logic signed [VAL_W-1:0] range_upper,
  dttfp_result_if.source          result
);

  // stage 1: captured job
  logic             v1;
  job_t             j1;
  // stage 2: partial products
  logic             v2;
  logic [63:0]      p_ll;
  logic [31:0]      p_hl;
  logic [31:0]      p_lh;
  logic             sat2;
  logic             neg2, adj2, zero2;
  // stage 3: scaled magnitude
  logic             v3;
  logic [VAL_W-1:0] mag3;
  logic             neg3, adj3, zero3;
  // output stage
  logic             vo;

  logic             rdy1, rdy2, rdy3, rdyo;
  logic [POW_W-1:0] mult;
  logic [31:0]      a_lo, m_lo;
  logic [31:0]      a_hi, m_hi;
  logic [VAL_W-1:0] neg_mag;

  assign rdyo      = !vo || result.ready;
  assign rdy3      = !v3 || rdyo;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign job_ready = rdy1;
  assign result.valid = vo;

  assign mult = pow10(j1.scale);
  assign a_lo = j1.acc[31:0];
  assign a_hi = 32'(j1.acc[ACC_W-1:32]);
  assign m_lo = mult[31:0];
  assign m_hi = 32'(mult[POW_W-1:32]);

  assign neg_mag = VAL_W'(0) - mag3;

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      vo <= 1'b0;
    end else begin
      if (rdy1) v1 <= job_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdyo) vo <= v3;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (rdy1) begin
      j1 <= job;
    end
    // low 64 bits of the product; the high-high term falls off the top
    if (rdy2) begin
      p_ll  <= 64'(a_lo) * 64'(m_lo);
      p_hl  <= 32'(a_hi * m_lo);
      p_lh  <= 32'(a_lo * m_hi);
      sat2  <= j1.acc > sat_div(j1.scale);
      neg2  <= j1.neg;
      adj2  <= j1.adj;
      zero2 <= j1.zero;
    end
    if (rdy3) begin
      mag3  <= sat2 ? VAL_W'(SAT_MAX) : p_ll + {p_hl + p_lh, 32'd0};
      adj3  <= adj2 || sat2;
      neg3  <= neg2;
      zero3 <= zero2;
    end
    // sign and range clamp; an empty text gives zero
    if (rdyo) begin
      if (zero3) begin
        result.value    <= '0;
        result.adjusted <= 1'b0;
      end else begin
        result.adjusted <= adj3;
        if (neg3) begin
          if (mag3 == VAL_W'(SAT_MAX) || $signed(neg_mag) < range_lower) begin
            result.value <= range_lower;
          end else begin
            result.value <= $signed(neg_mag);
          end
        end else if ($signed(mag3) > range_upper) begin
          result.value <= range_upper;
        end else begin
          result.value <= $signed(mag3);
        end
      end
    end
  end

endmodule

// ===== rtl/decimal_text_to_fixed_point_core.sv =====
// channel   dir  beat
// chars     in   glyph, last_char, empty_text
// cfg       in   index, data (register write, always ready)
// result    out  value, adjusted
//
// one character beat per cycle while the queue has room; the back end retires one queued
// beat per cycle unless a final beat waits for the pipeline; a result leaves through a
// four-stage scale and clamp pipeline (split 64-bit multiply, then sign and range clamp)
// rst is synchronous; registers return to period 46, no decimals, full signed range
// a stalled result backs up the pipeline, then the queue of four beats, then chars.ready
`include "decimal_text_to_fixed_point_core_defines.svh"

module decimal_text_to_fixed_point_core import dttfp_pkg::*; #(
  parameter int unsigned MAX_DECIMALS = 18
) (
  input  logic            clk,
  input  logic            rst,
  dttfp_char_if.sink      chars,
  dttfp_cfg_if.sink       cfg,
  dttfp_result_if.source  result
);

  logic [GLYPH_W-1:0]      period_code;
  logic [DEC_W-1:0]        decimal_places;
  logic signed [VAL_W-1:0] range_lower;
  logic signed [VAL_W-1:0] range_upper;

  logic          q_push;
  logic          q_pop;
  char_t         q_wr_ent;
  char_t         q_rd_ent;
  queue_status_t q_status;
  job_t          job;
  logic          job_valid;
  logic          job_ready;

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      period_code    <= 16'd46;
      decimal_places <= '0;
      range_lower    <= {1'b1, {(VAL_W-1){1'b0}}};
      range_upper    <= {1'b0, {(VAL_W-1){1'b1}}};
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_PERIOD_CODE:    period_code    <= cfg.data[GLYPH_W-1:0];
        REG_DECIMAL_PLACES: decimal_places <= cfg.data[DEC_W-1:0];
        REG_RANGE_LOWER:    range_lower    <= $signed(cfg.data);
        REG_RANGE_UPPER:    range_upper    <= $signed(cfg.data);
        default: ;
      endcase
    end
  end

  // classify characters
  dttfp_front u_front (
    .chars       (chars),
    .period_code (period_code),
    .q_status    (q_status),
    .push        (q_push),
    .ent         (q_wr_ent)
  );

  // decoupling queue
  dttfp_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_ent (q_wr_ent),
    .pop    (q_pop),
    .rd_ent (q_rd_ent),
    .status (q_status)
  );

  // digit accumulation and text state
  dttfp_back #(
    .MAX_DECIMALS (MAX_DECIMALS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .decimal_places (decimal_places),
    .q_status       (q_status),
    .ent            (q_rd_ent),
    .pop            (q_pop),
    .job            (job),
    .job_valid      (job_valid),
    .job_ready      (job_ready)
  );

  // scaling, sign and clamp
  dttfp_finish u_finish (
    .clk         (clk),
    .rst         (rst),
    .job         (job),
    .job_valid   (job_valid),
    .job_ready   (job_ready),
    .range_lower (range_lower),
    .range_upper (range_upper),
    .result      (result)
  );

  // checks
  `DTTFP_ASSERT_IMP(a_pop_needs_data, clk, rst, q_pop, !q_status.empty)
  `DTTFP_ASSERT_IMP(a_end_needs_room, clk, rst, q_pop && (q_rd_ent.last || q_rd_ent.empty), job_ready)
  `DTTFP_ASSERT_IMP(a_queue_level, clk, rst, 1'b1, !(q_status.full && q_status.empty))
  `DTTFP_ASSERT_NXT(a_reset_empty, clk, rst, $fell(rst), q_status.empty || q_push)

endmodule
